@@ design/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define BRF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent overlapping implication
`define BRF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent next-cycle implication
`define BRF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/brf_pkg.sv @@
`timescale 1ns / 1ps
package brf_pkg;

	// storage geometry
	localparam int DEPTH     = 256;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CAP_W     = IDX_W + 1;
	localparam int MAX_BURST = 8;
	localparam int LEN_W     = 4;
	localparam int LANE_W    = 3;

	// operation codes
	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_READ   = 2'd1,
		MODE_PEEK   = 2'd2,
		MODE_DELETE = 2'd3
	} mode_t;

	// input transaction
	typedef struct packed {
		mode_t             mode;
		logic [LEN_W-1:0]  length;
		logic [63:0]       write_bytes;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic              status;
		logic [63:0]       read_bytes;
		logic [7:0]        fill_count;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic cfg_wr;
		logic check;
		logic wr_step;
		logic rd_step;
		logic commit;
		logic finish;
	} brf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic  refused;
		logic  len_zero;
		mode_t mode;
		logic  last;
		logic  out_free;
	} brf_stat_t;

endpackage

@@ design/brf_datapath.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module brf_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  brf_pkg::in_item_t  in_item,
	input  logic [brf_pkg::CAP_W-1:0] cfg_data,
	input  brf_pkg::brf_cmd_t  cmd,
	input  logic               out_ready,
	output logic               out_valid,
	output brf_pkg::out_item_t out_item,
	output brf_pkg::brf_stat_t stat
);

	localparam int IDX_W = brf_pkg::IDX_W;
	localparam int CAP_W = brf_pkg::CAP_W;
	localparam int LEN_W = brf_pkg::LEN_W;

	logic [CAP_W-1:0]        cap_q;
	logic [IDX_W-1:0]        wr_idx_q;
	logic [IDX_W-1:0]        rd_idx_q;
	brf_pkg::mode_t          mode_q;
	logic [LEN_W-1:0]        len_q;
	logic [63:0]             data_q;
	logic [IDX_W-1:0]        ptr_q;
	logic [LEN_W-1:0]        cnt_q;
	logic [63:0]             acc_q;
	logic                    refused_q;
	logic [7:0]              rdata_s1;
	logic [brf_pkg::LANE_W-1:0] lane_s1;
	logic                    rvalid_s1;
	logic                    out_valid_q;
	brf_pkg::out_item_t      out_q;
	logic [7:0]              mem [brf_pkg::DEPTH];

	logic [CAP_W-1:0]        fill;
	logic [CAP_W-1:0]        free;
	logic [CAP_W-1:0]        cap_clamped;
	logic [CAP_W-1:0]        ptr_inc;
	logic [IDX_W-1:0]        ptr_next;
	logic [IDX_W-1:0]        base_idx;
	logic [CAP_W-1:0]        adv_sum;
	logic [IDX_W-1:0]        adv_idx;
	logic                    refused;

	// fill level from the two indices
	always_comb begin
		if (wr_idx_q >= rd_idx_q) begin
			fill = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
		end else begin
			fill = cap_q + {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
		end
		free = cap_q - CAP_W'(1) - fill;
	end

	// space and data check
	always_comb begin
		priority if (len_q > LEN_W'(brf_pkg::MAX_BURST)) begin
			refused = 1'b1;
		end else if (mode_q == brf_pkg::MODE_WRITE) begin
			refused = free < CAP_W'(len_q);
		end else begin
			refused = fill < CAP_W'(len_q);
		end
	end

	// capacity clamp
	always_comb begin
		priority if (cfg_data < CAP_W'(2)) begin
			cap_clamped = CAP_W'(2);
		end else if (cfg_data > CAP_W'(brf_pkg::DEPTH)) begin
			cap_clamped = CAP_W'(brf_pkg::DEPTH);
		end else begin
			cap_clamped = cfg_data;
		end
	end

	// slot pointer step with wrap at capacity
	always_comb begin
		ptr_inc  = {1'b0, ptr_q} + CAP_W'(1);
		ptr_next = (ptr_inc == cap_q) ? '0 : ptr_inc[IDX_W-1:0];
	end

	// index advance by the burst length, one compare and subtract
	always_comb begin
		base_idx = (mode_q == brf_pkg::MODE_WRITE) ? wr_idx_q : rd_idx_q;
		adv_sum  = {1'b0, base_idx} + CAP_W'(len_q);
		adv_idx  = (adv_sum >= cap_q) ? IDX_W'(adv_sum - cap_q) : adv_sum[IDX_W-1:0];
	end

	// capacity and indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_W'(brf_pkg::DEPTH);
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else if (cmd.cfg_wr) begin
			cap_q    <= cap_clamped;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else if (cmd.commit && !refused_q) begin
			unique case (mode_q)
				brf_pkg::MODE_WRITE:  wr_idx_q <= adv_idx;
				brf_pkg::MODE_READ,
				brf_pkg::MODE_DELETE: rd_idx_q <= adv_idx;
				default:              rd_idx_q <= rd_idx_q;
			endcase
		end
	end

	// transaction registers and burst walk
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= in_item.mode;
			len_q  <= in_item.length;
			data_q <= in_item.write_bytes;
			ptr_q  <= (in_item.mode == brf_pkg::MODE_WRITE) ? wr_idx_q : rd_idx_q;
			cnt_q  <= '0;
		end else if (cmd.wr_step || cmd.rd_step) begin
			data_q <= {8'h00, data_q[63:8]};
			ptr_q  <= ptr_next;
			cnt_q  <= cnt_q + LEN_W'(1);
		end
		if (cmd.check) begin
			refused_q <= refused;
		end
	end

	// byte store, one access per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_step) begin
			mem[ptr_q] <= data_q[7:0];
		end
		rdata_s1 <= mem[ptr_q];
		lane_s1  <= cnt_q[brf_pkg::LANE_W-1:0];
	end

	// read return valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.rd_step;
		end
	end

	// gather read bytes into their lanes
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (rvalid_s1) begin
			acc_q[{lane_s1, 3'b000} +: 8] <= rdata_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.status     <= refused_q;
			out_q.read_bytes <= acc_q;
			out_q.fill_count <= fill[7:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign out_item      = out_q;
	assign stat.refused  = refused;
	assign stat.len_zero = (len_q == '0);
	assign stat.mode     = mode_q;
	assign stat.last     = (cnt_q + LEN_W'(1)) == len_q;
	assign stat.out_free = !out_valid_q || out_ready;

	// indices always inside the ring
	`BRF_ASSERT(a_idx_range, (wr_idx_q < cap_q) && (rd_idx_q < cap_q), "index beyond capacity")
	// a refused transaction leaves the indices alone
	`BRF_ASSERT_NXT(a_refused_hold, cmd.commit && refused_q && !cmd.cfg_wr,
		$stable(wr_idx_q) && $stable(rd_idx_q), "refused transaction moved an index")
	// a result is never loaded over one still waiting
	`BRF_ASSERT_IMP(a_no_overwrite, cmd.finish, !out_valid_q || out_ready,
		"result register overwritten")

endmodule

@@ design/brf_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module brf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  brf_pkg::brf_stat_t stat,
	output brf_pkg::brf_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CHECK  = 7'b0000010,
		ST_WRITE  = 7'b0000100,
		ST_READ   = 7'b0001000,
		ST_DRAIN  = 7'b0010000,
		ST_COMMIT = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// configuration takes priority over a new transaction
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.cfg_wr  = cfg_valid && cfg_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.start = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				priority if (stat.refused || stat.len_zero
						|| stat.mode == brf_pkg::MODE_DELETE) begin
					state_d = ST_COMMIT;
				end else if (stat.mode == brf_pkg::MODE_WRITE) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_WRITE: begin
				cmd.wr_step = 1'b1;
				if (stat.last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_READ: begin
				cmd.rd_step = 1'b1;
				if (stat.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// the final byte of a burst always ends the walk
	`BRF_ASSERT_NXT(a_write_end, (state_q == ST_WRITE) && stat.last, state_q == ST_COMMIT,
		"write burst did not end on its last byte")
	`BRF_ASSERT_NXT(a_read_end, (state_q == ST_READ) && stat.last, state_q == ST_DRAIN,
		"read burst did not end on its last byte")

endmodule

@@ design/byte_ring_fifo_burst.sv @@
`timescale 1ns / 1ps
// channel   signals                          payload
// in        in_valid / in_ready              in_item   (mode, length, write_bytes)
// out       out_valid / out_ready            out_item  (status, read_bytes, fill_count)
// cfg       cfg_valid / cfg_ready            cfg_data  (capacity)
//
// one transaction at a time; the byte store is a single-port memory walked one byte
// per cycle; a write steps through check, the walk, commit and finish; a read or
// peek adds a drain after the walk; delete, empty or refused skip the walk.
// a waiting result sits in the output register while the next transaction runs;
// only the final load waits for out_ready.
// reset empties the ring and sets capacity to 256; store contents are not cleared.
`include "assert_macros.svh"
module byte_ring_fifo_burst (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  brf_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output brf_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [brf_pkg::CAP_W-1:0] cfg_data
);

	brf_pkg::brf_cmd_t  cmd;
	brf_pkg::brf_stat_t stat;

	// sequencer
	brf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// indices, store and result register
	brf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.stat      (stat)
	);

	// a configuration write and a transaction never land together
	`BRF_ASSERT(a_cfg_excl, !(in_valid && in_ready && cfg_valid && cfg_ready),
		"configuration and transaction accepted together")

endmodule

@@ tb/sv/tb_byte_ring_fifo_burst.sv @@
`timescale 1ns / 1ps
module tb_byte_ring_fifo_burst;
	import brf_pkg::*;

	// ring occupancy tracker and result checker
	class ring_scoreboard;
		int unsigned cap = DEPTH;
		int unsigned wr_idx = 0;
		int unsigned rd_idx = 0;
		logic [7:0] ring_bytes [DEPTH];
		out_item_t due_results [$];
		int unsigned errors = 0;
		int unsigned results_seen = 0;
		int unsigned refusals = 0;

		function int unsigned fill_level();
			if (wr_idx >= rd_idx)
				return wr_idx - rd_idx;
			return cap + wr_idx - rd_idx;
		endfunction

		// capacity write: clamp and empty the ring
		function void set_capacity(logic [CAP_W-1:0] value);
			if (value < 2)
				cap = 2;
			else if (value > DEPTH)
				cap = DEPTH;
			else
				cap = value;
			wr_idx = 0;
			rd_idx = 0;
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// work out the result of one accepted input transaction
		task note_transaction(in_item_t it);
			out_item_t want;
			int unsigned fill_now;
			int unsigned n;
			want = '0;
			fill_now = fill_level();
			n = it.length;
			if (n > MAX_BURST) begin
				want.status = 1'b1;
			end else if (it.mode == MODE_WRITE) begin
				if (cap - 1 - fill_now < n) begin
					want.status = 1'b1;
				end else begin
					for (int i = 0; i < n; i++)
						ring_bytes[(wr_idx + i) % cap] = it.write_bytes[8*i +: 8];
					wr_idx = (wr_idx + n) % cap;
				end
			end else begin
				if (fill_now < n) begin
					want.status = 1'b1;
				end else begin
					if (it.mode == MODE_READ || it.mode == MODE_PEEK)
						for (int i = 0; i < n; i++)
							want.read_bytes[8*i +: 8] = ring_bytes[(rd_idx + i) % cap];
					if (it.mode != MODE_PEEK)
						rd_idx = (rd_idx + n) % cap;
				end
			end
			want.fill_count = 8'(fill_level());
			if (want.status)
				refusals++;
			due_results.push_back(want);
		endtask

		// compare one result transaction with the oldest one due
		task check_result(out_item_t got);
			out_item_t want;
			results_seen++;
			if (due_results.size() == 0) begin
				report_mismatch("result with no transaction outstanding");
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status got %0b want %0b", got.status, want.status));
			if (got.read_bytes !== want.read_bytes)
				report_mismatch($sformatf("read_bytes got %h want %h",
					got.read_bytes, want.read_bytes));
			if (got.fill_count !== want.fill_count)
				report_mismatch($sformatf("fill_count got %0d want %0d",
					got.fill_count, want.fill_count));
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;

	ring_scoreboard sb = new;
	bit steady = 1'b0;
	int unsigned items_sent = 0;
	int unsigned cap_writes = 0;
	int unsigned drains = 0;

	byte_ring_fifo_burst DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("** byte_ring_fifo_burst: FAILED **");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_cycles(int unsigned floor_len);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return floor_len;
		if (r < 95)
			return floor_len + $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: ready with random stalls
	initial begin
		@(posedge arst_n);
		forever begin
			if (steady) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_ready <= 1'b0;
				repeat (gap_cycles(1)) @(posedge clk);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);
	end

	// present one input transaction and wait for its acceptance
	task automatic send_item(input in_item_t it);
		int unsigned g;
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_transaction(it);
		items_sent++;
		g = steady ? 0 : gap_cycles(0);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_op(input mode_t m, input int unsigned len, input logic [63:0] data);
		in_item_t it;
		it.mode = m;
		it.length = len[LEN_W-1:0];
		it.write_bytes = data;
		send_item(it);
	endtask

	// stop sending and wait until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0) @(posedge clk);
		drains++;
	endtask

	// capacity write while the block is idle
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_capacity(value);
		cap_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		// empty ring at reset capacity
		send_op(MODE_WRITE, 0, 64'h0);
		send_op(MODE_READ, 1, 64'h0);
		send_op(MODE_PEEK, 1, 64'h0);
		send_op(MODE_DELETE, 1, 64'h0);
		send_op(MODE_WRITE, 8, 64'hFFFF_FFFF_FFFF_FFFF);
		send_op(MODE_WRITE, 8, 64'h0);
		send_op(MODE_WRITE, 8, 64'h0123_4567_89AB_CDEF);
		send_op(MODE_PEEK, 8, 64'h0);
		send_op(MODE_READ, 8, 64'h0);
		send_op(MODE_DELETE, 8, 64'h0);
		send_op(MODE_READ, 8, 64'h0);
		send_op(MODE_READ, 0, 64'h0);
		send_op(MODE_PEEK, 0, 64'h0);
		send_op(MODE_DELETE, 0, 64'h0);
		// over-long bursts are refused
		send_op(MODE_WRITE, 9, 64'hFFFF_FFFF_FFFF_FFFF);
		send_op(MODE_WRITE, 15, 64'hA5A5_A5A5_A5A5_A5A5);
		send_op(MODE_READ, 15, 64'h0);
		send_op(MODE_PEEK, 9, 64'h0);
		send_op(MODE_DELETE, 12, 64'h0);
		// capacity below range clamps to two: a single usable slot
		write_capacity(0);
		send_op(MODE_WRITE, 1, 64'h5A);
		send_op(MODE_WRITE, 1, 64'hC3);
		send_op(MODE_READ, 1, 64'h0);
		send_op(MODE_READ, 1, 64'h0);
		// full ring and a write that wraps
		write_capacity(9);
		send_op(MODE_WRITE, 8, 64'h8877_6655_4433_2211);
		send_op(MODE_WRITE, 1, 64'hEE);
		send_op(MODE_READ, 3, 64'h0);
		send_op(MODE_WRITE, 3, 64'hCC_BBAA);
		send_op(MODE_PEEK, 8, 64'h0);
		send_op(MODE_DELETE, 8, 64'h0);
	endtask

	// one random phase at a given capacity
	task automatic run_phase(input logic [CAP_W-1:0] cap_value, input int unsigned count);
		in_item_t it;
		int unsigned stretch;
		bit writes_first;
		int unsigned r;
		write_capacity(cap_value);
		writes_first = 1'b1;
		stretch = $urandom_range(8, 20 + sb.cap / 2);
		for (int k = 0; k < count; k++) begin
			if (stretch == 0) begin
				writes_first = ~writes_first;
				stretch = $urandom_range(8, 20 + sb.cap / 2);
			end
			stretch--;
			r = $urandom_range(0, 99);
			if (r < (writes_first ? 70 : 30))
				it.mode = MODE_WRITE;
			else if (r < (writes_first ? 82 : 62))
				it.mode = MODE_READ;
			else if (r < (writes_first ? 91 : 81))
				it.mode = MODE_PEEK;
			else
				it.mode = MODE_DELETE;
			r = $urandom_range(0, 99);
			if (r < 10)
				it.length = LEN_W'($urandom_range(MAX_BURST + 1, 15));
			else if (r < 30)
				it.length = LEN_W'(MAX_BURST);
			else
				it.length = LEN_W'($urandom_range(0, MAX_BURST));
			r = $urandom_range(0, 19);
			if (r == 0)
				it.write_bytes = '1;
			else if (r == 1)
				it.write_bytes = '0;
			else
				it.write_bytes = {$urandom, $urandom};
			send_item(it);
			// occasional hold-off until the block has answered everything
			if ($urandom_range(0, 59) == 0)
				drain();
		end
	endtask

	// stimulus
	initial begin
		logic [CAP_W-1:0] phase_caps [12];
		phase_caps = '{2, 1, 3, 9, 17, 100, 255, 256, 257, 511, 0, 0};
		phase_caps[11] = CAP_W'($urandom_range(0, 511));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < 12; p++) begin
			steady = (p == 4 || p == 9);
			run_phase(phase_caps[p], 95);
		end
		steady = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (sb.due_results.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.due_results.size()));
		$display("covered %0d transactions (%0d refused), %0d results, %0d capacity writes",
			items_sent, sb.refusals, sb.results_seen, cap_writes);
		$display("sender held off %0d times; %0d mismatches", drains, sb.errors);
		if (sb.errors == 0)
			$display("** byte_ring_fifo_burst: PASSED **");
		else
			$display("** byte_ring_fifo_burst: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/brf_pkg.sv
design/brf_datapath.sv
design/brf_ctrl.sv
design/byte_ring_fifo_burst.sv
tb/sv/tb_byte_ring_fifo_burst.sv
